### design/assert_macros.svh
// Assertion macros used by the bracket scope capture core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define ASSERT_IMP(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("assertion failed");

`endif

### design/bsc_pkg.sv
// Types, constants and register codes for the bracket scope capture core.
package bsc_pkg;

	localparam int DEPTH_BITS_DEF  = 8;
	localparam int LENGTH_BITS_DEF = 16;
	localparam int BYTE_W          = 8;
	localparam int REPORT_W        = 16;
	localparam int STATUS_W        = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OPEN         = 3'd0,
		ST_BODY         = 3'd1,
		ST_CLOSED       = 3'd2,
		ST_NO_OPENER    = 3'd3,
		ST_UNTERMINATED = 3'd4
	} status_t;

	typedef enum logic {
		REG_OPENER = 1'b0,
		REG_CLOSER = 1'b1
	} reg_idx_t;

	localparam logic [BYTE_W-1:0] OPENER_RST = 8'd40;
	localparam logic [BYTE_W-1:0] CLOSER_RST = 8'd41;

	localparam logic [BYTE_W-1:0] CH_ROUND_L  = 8'h28;
	localparam logic [BYTE_W-1:0] CH_ROUND_R  = 8'h29;
	localparam logic [BYTE_W-1:0] CH_SQUARE_L = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_SQUARE_R = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_CURLY_L  = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_CURLY_R  = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_POINTY_L = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_POINTY_R = 8'h3E;

	typedef struct packed {
		logic clr;
		logic inc;
		logic dec;
	} depth_ctl_t;

endpackage

### design/bracket_scope_capture_core.sv
// Top level of the bracket scope capture core: handshake, scope control and result register.
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while results are taken; the result register frees whenever it is taken.
// Scope state, depths and count are updated in the cycle a word is accepted.
// Reset (arst_n, asynchronous, active low) returns to idle, clears depths and count,
// and loads the opener and closer registers with '(' and ')'.
module bracket_scope_capture_core #(
	parameter int DEPTH_BITS  = bsc_pkg::DEPTH_BITS_DEF,
	parameter int LENGTH_BITS = bsc_pkg::LENGTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bsc_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// Fields from bit 0: data_byte[7:0].
	input  logic [7:0]                    s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// Fields from bit 0: body_byte[7:0], body_length[23:8].
	output logic [23:0]                   m_axis_tdata,
	// Fields from bit 0: status[2:0].
	output logic [bsc_pkg::STATUS_W-1:0]  m_axis_tuser
);
	import bsc_pkg::*;

	localparam int CMP_W = (LENGTH_BITS > REPORT_W) ? LENGTH_BITS : REPORT_W;

	logic [BYTE_W-1:0]      opener_q;
	logic [BYTE_W-1:0]      closer_q;
	logic                   in_scope_q;
	logic [LENGTH_BITS-1:0] count_q;

	logic                   s_fire;
	logic [BYTE_W-1:0]      b;
	logic                   eos;
	logic                   all_zero;
	logic                   z_round, z_square, z_curly, z_pointy;
	depth_ctl_t             ctl_round, ctl_square, ctl_curly, ctl_pointy;

	logic                   scope_next;
	logic [LENGTH_BITS-1:0] count_next;
	logic [CMP_W-1:0]       count_ext;
	logic [REPORT_W-1:0]    report_len;
	status_t                status_d;
	logic [BYTE_W-1:0]      body_d;
	logic [REPORT_W-1:0]    length_d;
	logic                   clr_all;
	logic                   bump;

	status_t                status_q;
	logic [BYTE_W-1:0]      body_q;
	logic [REPORT_W-1:0]    length_q;
	logic                   out_valid_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;
	assign eos           = s_axis_tlast;
	assign all_zero      = z_round && z_square && z_curly && z_pointy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opener_q <= OPENER_RST;
			closer_q <= CLOSER_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_OPENER: opener_q <= cfg_data;
				REG_CLOSER: closer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		scope_next = in_scope_q;
		count_next = count_q;
		status_d   = ST_NO_OPENER;
		body_d     = '0;
		clr_all    = 1'b0;
		bump       = 1'b0;
		priority if (!in_scope_q) begin
			if (!eos && b == opener_q) begin
				scope_next = 1'b1;
				clr_all    = 1'b1;
				count_next = '0;
				status_d   = ST_OPEN;
			end
		end else if (eos) begin
			scope_next = 1'b0;
			clr_all    = 1'b1;
			count_next = '0;
			status_d   = ST_UNTERMINATED;
		end else if (all_zero && b == closer_q) begin
			scope_next = 1'b0;
			clr_all    = 1'b1;
			count_next = '0;
			status_d   = ST_CLOSED;
		end else begin
			bump     = 1'b1;
			status_d = ST_BODY;
			body_d   = b;
			if (count_q != '1) begin
				count_next = count_q + LENGTH_BITS'(1);
			end
		end
	end

	// Body words report the count including themselves; close and end report the count so far.
	always_comb begin
		count_ext = (status_d == ST_BODY) ? CMP_W'(count_next) : CMP_W'(count_q);
		if (count_ext > CMP_W'({REPORT_W{1'b1}})) begin
			report_len = '1;
		end else begin
			report_len = count_ext[REPORT_W-1:0];
		end
		if (status_d == ST_BODY || status_d == ST_CLOSED || status_d == ST_UNTERMINATED) begin
			length_d = report_len;
		end else begin
			length_d = '0;
		end
	end

	always_comb begin
		ctl_round  = '{clr: s_fire && clr_all, inc: s_fire && bump && b == CH_ROUND_L,
		               dec: s_fire && bump && b == CH_ROUND_R};
		ctl_square = '{clr: s_fire && clr_all, inc: s_fire && bump && b == CH_SQUARE_L,
		               dec: s_fire && bump && b == CH_SQUARE_R};
		ctl_curly  = '{clr: s_fire && clr_all, inc: s_fire && bump && b == CH_CURLY_L,
		               dec: s_fire && bump && b == CH_CURLY_R};
		ctl_pointy = '{clr: s_fire && clr_all, inc: s_fire && bump && b == CH_POINTY_L,
		               dec: s_fire && bump && b == CH_POINTY_R};
	end

	bsc_depth_ctr #(.DEPTH_BITS(DEPTH_BITS)) u_round (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_round), .is_zero(z_round)
	);
	bsc_depth_ctr #(.DEPTH_BITS(DEPTH_BITS)) u_square (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_square), .is_zero(z_square)
	);
	bsc_depth_ctr #(.DEPTH_BITS(DEPTH_BITS)) u_curly (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_curly), .is_zero(z_curly)
	);
	bsc_depth_ctr #(.DEPTH_BITS(DEPTH_BITS)) u_pointy (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_pointy), .is_zero(z_pointy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_scope_q  <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				in_scope_q  <= scope_next;
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			status_q <= status_d;
			body_q   <= body_d;
			length_q <= length_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {length_q, body_q};
	assign m_axis_tuser  = status_q;

`include "assert_macros.svh"

	`ASSERT_NEXT(a_no_opener, s_fire && !in_scope_q && (eos || b != opener_q), m_axis_tvalid && m_axis_tuser == ST_NO_OPENER)
	`ASSERT_NEXT(a_eos_exit, s_fire && in_scope_q && eos, !in_scope_q && m_axis_tuser == ST_UNTERMINATED)
	`ASSERT_IMP(a_body_len, m_axis_tvalid && m_axis_tuser == ST_BODY, m_axis_tdata[23:8] != '0)

endmodule

### design/bsc_depth_ctr.sv
// Saturating signed nesting depth counter for one bracket kind.
module bsc_depth_ctr #(
	parameter int DEPTH_BITS = bsc_pkg::DEPTH_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bsc_pkg::depth_ctl_t ctl,
	output logic                is_zero
);
	import bsc_pkg::*;

	localparam logic signed [DEPTH_BITS-1:0] D_HI = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic signed [DEPTH_BITS-1:0] D_LO = {1'b1, {(DEPTH_BITS-1){1'b0}}};

	logic signed [DEPTH_BITS-1:0] depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			priority if (ctl.clr) begin
				depth_q <= '0;
			end else if (ctl.inc && depth_q != D_HI) begin
				depth_q <= depth_q + DEPTH_BITS'(1);
			end else if (ctl.dec && depth_q != D_LO) begin
				depth_q <= depth_q - DEPTH_BITS'(1);
			end else begin
				depth_q <= depth_q;
			end
		end
	end

	assign is_zero = (depth_q == '0);

endmodule
